// ===== design/assert_macros.svh =====
// Assertion helpers shared by the biquad RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/biquad_pkg.sv =====
// ----------------------------------------------------------------------------
// biquad_pkg
// Shared constants and types for the direct form I biquad: coefficient
// format, register map, and the command/status bundle between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package biquad_pkg;

    // Coefficient format: signed Q2.14 in 16 bits
    localparam int COEF_WIDTH          = 16;
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF  = 14;

    // Register map
    localparam int NUM_REGS   = 6;
    localparam int REG_ADDR_W = 3;

    typedef enum logic [REG_ADDR_W-1:0] {
        REG_GAIN = 3'd0,
        REG_B0   = 3'd1,
        REG_B1   = 3'd2,
        REG_B2   = 3'd3,
        REG_A1   = 3'd4,
        REG_A2   = 3'd5
    } reg_index_t;

    // Reset values; 16384 is 1.0 in Q2.14
    localparam logic signed [COEF_WIDTH-1:0] UNITY_Q14 = 16'sd16384;
    localparam logic signed [COEF_WIDTH-1:0] ZERO_Q14  = 16'sd0;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] gain;
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } coef_set_t;

    // Multiplier operand pair
    typedef enum logic [2:0] {
        MUL_GAIN = 3'd0,   // gain * sample
        MUL_B0   = 3'd1,   // b0 * x0
        MUL_B1   = 3'd2,   // b1 * x1
        MUL_B2   = 3'd3,   // b2 * x2
        MUL_A1   = 3'd4,   // a1 * y1
        MUL_A2   = 3'd5    // a2 * y2
    } mul_op_t;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic    cap_in;    // capture input beat
        mul_op_t mul_op;    // operands for the product register
        acc_op_t acc_op;    // accumulator update from the product register
        logic    x0_load;   // latch rounded scaled input
        logic    wb;        // load output register, shift histories
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;     // output register empty or draining this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR filter, direct form I, Q2.14 gain and coefficients, with
// a shared multiply-accumulate datapath and rounded, saturated output.
//
//   channel   signals                            handshake
//   input     in_valid / in_ready, sample_in     valid-ready beat
//   output    out_valid / out_ready, sample_out  valid-ready beat
//   config    cfg_we, cfg_addr, cfg_wdata        write on cfg_we, no wait
//
// A sample runs from accept to write-back through the accept state, the gain
// product and its load into the accumulator, five filter products through
// the single shared multiplier and accumulator, and the write-back. The next
// beat is accepted right after.
// Reset clears the histories to zero and loads gain = b0 = 1.0, others zero.
// Write-back holds only while the previous output beat is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH   = biquad_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = biquad_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    input  logic                                cfg_we,
    input  logic [biquad_pkg::REG_ADDR_W-1:0]   cfg_addr,
    input  logic [biquad_pkg::COEF_WIDTH-1:0]   cfg_wdata
);
    import biquad_pkg::*;

    coef_set_t  coefs;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers
    biquad_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .coefs     (coefs)
    );

    // Sequencer
    biquad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Multiply-accumulate datapath
    biquad_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .coefs      (coefs),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire

// ===== design/biquad_cfg.sv =====
// ----------------------------------------------------------------------------
// biquad_cfg
// Configuration register file: gain and five coefficients, written by index.
// Writes to an index beyond the map are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [biquad_pkg::REG_ADDR_W-1:0]     cfg_addr,
    input  logic [biquad_pkg::COEF_WIDTH-1:0]     cfg_wdata,
    output biquad_pkg::coef_set_t                 coefs
);
    import biquad_pkg::*;

    coef_set_t coef_reg;
    coef_set_t coef_next;

    // Decode the write
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_GAIN: coef_next.gain = cfg_wdata;
                REG_B0:   coef_next.b0   = cfg_wdata;
                REG_B1:   coef_next.b1   = cfg_wdata;
                REG_B2:   coef_next.b2   = cfg_wdata;
                REG_A1:   coef_next.a1   = cfg_wdata;
                REG_A2:   coef_next.a2   = cfg_wdata;
                default:  coef_next      = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.gain <= UNITY_Q14;
            coef_reg.b0   <= UNITY_Q14;
            coef_reg.b1   <= ZERO_Q14;
            coef_reg.b2   <= ZERO_Q14;
            coef_reg.a1   <= ZERO_Q14;
            coef_reg.a2   <= ZERO_Q14;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

`default_nettype wire

// ===== design/biquad_ctrl.sv =====
// ----------------------------------------------------------------------------
// biquad_ctrl
// Sequencer for one sample: gain product, then five products through the
// shared multiplier and accumulator, then write-back to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module biquad_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  biquad_pkg::dp_status_t  status,
    output biquad_pkg::dp_cmd_t     cmd
);
    import biquad_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_GAIN  = 9'b000000010,
        ST_LOADG = 9'b000000100,
        ST_X0    = 9'b000001000,
        ST_T2    = 9'b000010000,
        ST_T3    = 9'b000100000,
        ST_T4    = 9'b001000000,
        ST_LAST  = 9'b010000000,
        ST_WB    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.cap_in  = 1'b0;
        cmd.mul_op  = MUL_GAIN;
        cmd.acc_op  = ACC_HOLD;
        cmd.x0_load = 1'b0;
        cmd.wb      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.cap_in = in_valid;
                if (in_valid)
                    state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.mul_op = MUL_GAIN;
                state_next = ST_LOADG;
            end
            ST_LOADG:
            begin
                // acc takes gain*x for rounding; start b1*x1
                cmd.acc_op = ACC_LOAD;
                cmd.mul_op = MUL_B1;
                state_next = ST_X0;
            end
            ST_X0:
            begin
                // latch x0, restart acc with b1*x1
                cmd.x0_load = 1'b1;
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_op  = MUL_B2;
                state_next  = ST_T2;
            end
            ST_T2:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.mul_op = MUL_A1;
                state_next = ST_T3;
            end
            ST_T3:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.mul_op = MUL_A2;
                state_next = ST_T4;
            end
            ST_T4:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.mul_op = MUL_B0;
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                // wait for room in the output register
                if (status.out_free)
                begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    `BQ_ASSERT_IMPL(a_wb_needs_room, cmd.wb, status.out_free, "write-back with output full")
    `BQ_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == ST_GAIN,
                    "accepted beat did not start the sequence")

endmodule

`default_nettype wire

// ===== design/biquad_dp.sv =====
// ----------------------------------------------------------------------------
// biquad_dp
// Datapath: one shared signed multiplier with a registered product, a wide
// accumulator, a round-half-up and saturate unit, sample histories, and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module biquad_dp #(
    parameter int SAMPLE_WIDTH   = biquad_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = biquad_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  biquad_pkg::dp_cmd_t            cmd,
    output biquad_pkg::dp_status_t         status,
    input  biquad_pkg::coef_set_t          coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out
);
    import biquad_pkg::*;

    localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam int RND_W  = ((ACC_W > COEF_FRAC_BITS) ? ACC_W : COEF_FRAC_BITS) + 1;

    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(RND_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] x0_reg;
    logic signed [SAMPLE_WIDTH-1:0] xh1_reg;
    logic signed [SAMPLE_WIDTH-1:0] xh2_reg;
    logic signed [SAMPLE_WIDTH-1:0] yh1_reg;
    logic signed [SAMPLE_WIDTH-1:0] yh2_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [COEF_WIDTH-1:0]   mul_coef;
    logic signed [SAMPLE_WIDTH-1:0] mul_data;
    logic signed [RND_W-1:0]        rnd_sum;
    logic signed [RND_W-1:0]        rnd_shift;
    logic signed [SAMPLE_WIDTH-1:0] rnd_sat;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // Operand select for the shared multiplier
    always_comb
    begin
        case (cmd.mul_op)
            MUL_GAIN:
            begin
                mul_coef = coefs.gain;
                mul_data = sample_reg;
            end
            MUL_B0:
            begin
                mul_coef = coefs.b0;
                mul_data = x0_reg;
            end
            MUL_B1:
            begin
                mul_coef = coefs.b1;
                mul_data = xh1_reg;
            end
            MUL_B2:
            begin
                mul_coef = coefs.b2;
                mul_data = xh2_reg;
            end
            MUL_A1:
            begin
                mul_coef = coefs.a1;
                mul_data = yh1_reg;
            end
            MUL_A2:
            begin
                mul_coef = coefs.a2;
                mul_data = yh2_reg;
            end
            default:
            begin
                mul_coef = coefs.gain;
                mul_data = sample_reg;
            end
        endcase
    end

    // Full-width signed product
    assign prod_next = mul_coef * mul_data;
    assign prod_ext  = ACC_W'(prod_reg);

    // Accumulator update
    always_comb
    begin
        case (cmd.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // Round half up by the fraction bits, then clamp to the sample range
    always_comb
    begin
        rnd_sum   = RND_W'(acc_reg) + RND_HALF;
        rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
        if (rnd_shift > SAT_HI)
            rnd_sat = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (rnd_shift < SAT_LO)
            rnd_sat = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            rnd_sat = rnd_shift[SAMPLE_WIDTH-1:0];
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.cap_in)
            sample_reg <= sample_in;
        if (cmd.x0_load)
            x0_reg <= rnd_sat;
        if (cmd.wb)
            sample_out_reg <= rnd_sat;
    end

    // Filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh1_reg <= '0;
            xh2_reg <= '0;
            yh1_reg <= '0;
            yh2_reg <= '0;
        end
        else if (cmd.wb)
        begin
            xh2_reg <= xh1_reg;
            xh1_reg <= x0_reg;
            yh2_reg <= yh1_reg;
            yh1_reg <= rnd_sat;
        end
    end

    // Output beat handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.wb)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;

    `BQ_ASSERT_NEXT(a_wb_sets_valid, cmd.wb, out_valid_reg, "write-back lost the output beat")
    `BQ_ASSERT_NEXT(a_wb_hist_match, cmd.wb, sample_out_reg == yh1_reg,
                    "output and feedback history disagree")

endmodule

`default_nettype wire
